[hdl/kvzc_pkg.sv]
// Shared types and constants for the key/velocity zone classifier.
package kvzc_pkg;

    localparam int MAX_ZONES_DEFAULT = 16;

    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_RESOLVE = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    typedef struct packed {
        logic [6:0] key_lo;
        logic [6:0] key_hi;
        logic [6:0] vel_lo;
        logic [6:0] vel_hi;
        logic [7:0] chain;
    } zone_entry_t;

endpackage

[hdl/key_velocity_zone_classifier_top.sv]
// Zone table with append/insert/remove/clear/read and first-match note resolve.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | request type, index, zone, note
//  m_      | out       | m_valid / m_ready  | ok, index, count, entry fields
//
// One request at a time; one range comparator and one table read port are shared.
// Per request, m_valid rises as s_ready returns.
// Append, clear and bad requests go straight to the result; read waits on the table.
// Insert moves entries index..count-1 up one at a time, then writes the zone;
// remove moves the entries above index down; resolve scans up from entry 0 until a hit.
// Synchronous active-low reset empties the table; a stalled m_ side holds
// the sequencer in its final state while the next request may still wait.
module key_velocity_zone_classifier_top #(
    parameter int MAX_ZONES = kvzc_pkg::MAX_ZONES_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [4:0] s_zone_index,
    input  logic [6:0] s_low_key,
    input  logic [6:0] s_high_key,
    input  logic [6:0] s_low_velocity,
    input  logic [6:0] s_high_velocity,
    input  logic [7:0] s_chain_number,
    input  logic [6:0] s_note_key,
    input  logic [6:0] s_note_velocity,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_ok,
    output logic [3:0] m_result_index,
    output logic [4:0] m_zone_count,
    output logic [6:0] m_entry_low_key,
    output logic [6:0] m_entry_high_key,
    output logic [6:0] m_entry_low_velocity,
    output logic [6:0] m_entry_high_velocity,
    output logic [7:0] m_entry_chain
);

    localparam int AW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int CW = $clog2(MAX_ZONES + 1);
    localparam int XW = ((CW > 5) ? CW : 5) + 1;
    localparam int RW = (AW > 4) ? AW : 4;
    localparam int NW = (CW > 5) ? CW : 5;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EXEC      = 4'd1;
    localparam logic [3:0] S_UP_RD     = 4'd2;
    localparam logic [3:0] S_UP_WR     = 4'd3;
    localparam logic [3:0] S_INS_WR    = 4'd4;
    localparam logic [3:0] S_DN_RD     = 4'd5;
    localparam logic [3:0] S_DN_WR     = 4'd6;
    localparam logic [3:0] S_SCAN_RD   = 4'd7;
    localparam logic [3:0] S_SCAN_CMP  = 4'd8;
    localparam logic [3:0] S_READ_WAIT = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    kvzc_pkg::zone_entry_t mem [MAX_ZONES];

    logic [3:0]            state_reg, state_next;
    logic [CW-1:0]         total_reg, total_next;
    logic                  m_valid_reg, m_valid_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [2:0]            req_reg, req_next;
    logic [4:0]            idx_reg, idx_next;
    kvzc_pkg::zone_entry_t zone_reg, zone_next;
    logic [6:0]            note_key_reg, note_key_next;
    logic [6:0]            note_vel_reg, note_vel_next;
    logic                  ok_reg, ok_next;
    logic [AW-1:0]         res_reg, res_next;
    kvzc_pkg::zone_entry_t entry_reg, entry_next;
    kvzc_pkg::zone_entry_t rd_data_reg;
    logic                  m_ok_reg, m_ok_next;
    logic [3:0]            m_res_reg, m_res_next;
    logic [4:0]            m_count_reg, m_count_next;
    kvzc_pkg::zone_entry_t m_entry_reg, m_entry_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    kvzc_pkg::zone_entry_t mem_wdata;

    logic [AW-1:0] idx_a, ptr_inc, ptr_dec;
    logic [XW-1:0] idx_x, total_x, ptr_x, max_x;
    logic [RW-1:0] res_ext;
    logic [NW-1:0] count_ext;
    logic          hit;

    assign idx_a     = AW'(idx_reg);
    assign ptr_inc   = ptr_reg + AW'(1);
    assign ptr_dec   = ptr_reg - AW'(1);
    assign idx_x     = XW'(idx_reg);
    assign total_x   = XW'(total_reg);
    assign ptr_x     = XW'(ptr_reg);
    assign max_x     = XW'(MAX_ZONES);
    assign res_ext   = RW'(res_reg);
    assign count_ext = NW'(total_reg);

    assign hit = (note_key_reg >= rd_data_reg.key_lo)
              && (note_key_reg <= rd_data_reg.key_hi)
              && (note_vel_reg >= rd_data_reg.vel_lo)
              && (note_vel_reg <= rd_data_reg.vel_hi);

    always_comb begin
        state_next    = state_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg;
        ptr_next      = ptr_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        zone_next     = zone_reg;
        note_key_next = note_key_reg;
        note_vel_next = note_vel_reg;
        ok_next       = ok_reg;
        res_next      = res_reg;
        entry_next    = entry_reg;
        m_ok_next     = m_ok_reg;
        m_res_next    = m_res_reg;
        m_count_next  = m_count_reg;
        m_entry_next  = m_entry_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = zone_reg;
        mem_raddr     = ptr_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next         = s_req_type;
                    idx_next         = s_zone_index;
                    zone_next.key_lo = s_low_key;
                    zone_next.key_hi = s_high_key;
                    zone_next.vel_lo = s_low_velocity;
                    zone_next.vel_hi = s_high_velocity;
                    zone_next.chain  = s_chain_number;
                    note_key_next    = s_note_key;
                    note_vel_next    = s_note_velocity;
                    state_next       = S_EXEC;
                end
            end
            S_EXEC: begin
                ok_next    = 1'b0;
                res_next   = '0;
                entry_next = '0;
                state_next = S_DONE;
                case (req_reg)
                    kvzc_pkg::REQ_APPEND: begin
                        if (total_x < max_x) begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(total_reg);
                            res_next   = AW'(total_reg);
                            total_next = total_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    kvzc_pkg::REQ_INSERT: begin
                        if (total_x < max_x && idx_x <= total_x) begin
                            ptr_next = AW'(total_reg);
                            if (idx_x == total_x) begin
                                state_next = S_INS_WR;
                            end else begin
                                state_next = S_UP_RD;
                            end
                        end
                    end
                    kvzc_pkg::REQ_REMOVE: begin
                        if (idx_x < total_x) begin
                            ptr_next = idx_a;
                            if (idx_x + XW'(1) < total_x) begin
                                state_next = S_DN_RD;
                            end else begin
                                total_next = total_reg - CW'(1);
                                ok_next    = 1'b1;
                            end
                        end
                    end
                    kvzc_pkg::REQ_CLEAR: begin
                        total_next = '0;
                        ok_next    = 1'b1;
                    end
                    kvzc_pkg::REQ_RESOLVE: begin
                        ptr_next = '0;
                        if (total_reg != '0) begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    kvzc_pkg::REQ_READ: begin
                        if (idx_x < total_x) begin
                            mem_raddr  = idx_a;
                            state_next = S_READ_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UP_RD: begin
                mem_raddr  = ptr_dec;
                state_next = S_UP_WR;
            end
            S_UP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_dec;
                if (ptr_dec == idx_a) begin
                    state_next = S_INS_WR;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_INS_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_a;
                mem_wdata  = zone_reg;
                total_next = total_reg + CW'(1);
                res_next   = idx_a;
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DN_RD: begin
                mem_raddr  = ptr_inc;
                state_next = S_DN_WR;
            end
            S_DN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_inc;
                if (ptr_x + XW'(2) < total_x) begin
                    state_next = S_DN_RD;
                end else begin
                    total_next = total_reg - CW'(1);
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SCAN_RD: begin
                mem_raddr  = ptr_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    ok_next          = 1'b1;
                    res_next         = ptr_reg;
                    entry_next.chain = rd_data_reg.chain;
                    state_next       = S_DONE;
                end else if (ptr_x + XW'(1) < total_x) begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_READ_WAIT: begin
                entry_next = rd_data_reg;
                res_next   = idx_a;
                ok_next    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_res_next   = res_ext[3:0];
                    m_count_next = count_ext[4:0];
                    m_entry_next = entry_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        zone_reg     <= zone_next;
        note_key_reg <= note_key_next;
        note_vel_reg <= note_vel_next;
        ok_reg       <= ok_next;
        res_reg      <= res_next;
        entry_reg    <= entry_next;
        m_ok_reg     <= m_ok_next;
        m_res_reg    <= m_res_next;
        m_count_reg  <= m_count_next;
        m_entry_reg  <= m_entry_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign s_ready               = (state_reg == S_IDLE);
    assign m_valid               = m_valid_reg;
    assign m_ok                  = m_ok_reg;
    assign m_result_index        = m_res_reg;
    assign m_zone_count          = m_count_reg;
    assign m_entry_low_key       = m_entry_reg.key_lo;
    assign m_entry_high_key      = m_entry_reg.key_hi;
    assign m_entry_low_velocity  = m_entry_reg.vel_lo;
    assign m_entry_high_velocity = m_entry_reg.vel_hi;
    assign m_entry_chain         = m_entry_reg.chain;

endmodule

[hdl/kvzc_checker.sv]
// Port-level checks for the zone classifier, bound to the top level.
module kvzc_checker #(
    parameter int MAX_ZONES = kvzc_pkg::MAX_ZONES_DEFAULT
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_ok,
    input logic [3:0] m_result_index,
    input logic [4:0] m_zone_count,
    input logic [6:0] m_entry_low_key,
    input logic [6:0] m_entry_high_key,
    input logic [6:0] m_entry_low_velocity,
    input logic [6:0] m_entry_high_velocity,
    input logic [7:0] m_entry_chain
);

    localparam int CW = $clog2(MAX_ZONES + 1);
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after a transaction");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (XW'(m_zone_count) <= XW'(MAX_ZONES)) || (MAX_ZONES > 31))
        else $error("zone count above table size");

    a_fail_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_result_index == 4'd0 && m_entry_chain == 8'd0
            && m_entry_low_key == 7'd0 && m_entry_high_key == 7'd0
            && m_entry_low_velocity == 7'd0 && m_entry_high_velocity == 7'd0))
        else $error("failed transaction carries nonzero fields");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_zone_count) && $stable(m_ok)))
        else $error("stalled result changed");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind key_velocity_zone_classifier_top kvzc_checker #(.MAX_ZONES(MAX_ZONES)) u_kvzc_checker (.*);
